>>> hdl/gbf_pkg.sv
// gbf_pkg: shared constants and types for the gaussian beam fusion block
// no dependencies; imported by gaussian_beam_fusion
`timescale 1ns / 1ps
`default_nettype none

package gbf_pkg;

  localparam int CFG_W    = 13;
  localparam int COL_W    = 12;
  localparam int PIX_W    = 32;
  localparam int WEIGHT_W = 17;

  // exp(-1/200) in q0.32, step of the weight recurrence
  localparam logic [31:0] DECAY_Q32 = 32'd4273546057;
  // ceil(2^18 / 6), exact divide by six for 13-bit widths
  localparam logic [15:0] RECIP6    = 16'd43691;
  localparam int          RECIP6_SH = 18;

  // register index codes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [CFG_W-1:0]           cfg_t;
  typedef logic [COL_W-1:0]           coord_t;
  typedef logic signed [PIX_W-1:0]    pixel_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;

endpackage

`default_nettype wire

>>> hdl/gaussian_beam_fusion.sv
// gaussian_beam_fusion: three-beam gaussian weighted pixel fusion, deep pipeline
// depends on gbf_pkg
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | column, row, left, center, right pixel
//   out_    | output    | out_valid / out_ready| fused value, last pixel flag
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// one transaction per cycle while the output is not stalled; the pipeline is 7 front stages (input, distance,
// square, table index, weight rom, products, sums), the divider setup register,
// the 16-stage radix-4 restoring divider and the output register.
// the whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage, bubbles included.
// synchronous reset clears valid bits and sets the config registers to 64 x 64.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_beam_fusion #(
  parameter int MAX_COLUMNS        = 4096,
  parameter int WEIGHT_TABLE_DEPTH = 4096
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire gbf_pkg::coord_t  in_column_index,
  input  wire gbf_pkg::coord_t  in_row_index,
  input  wire gbf_pkg::pixel_t  in_left_value,
  input  wire gbf_pkg::pixel_t  in_center_value,
  input  wire gbf_pkg::pixel_t  in_right_value,
  output logic                  out_valid,
  input  wire                   out_ready,
  output gbf_pkg::pixel_t       out_fused_value,
  output logic                  out_last_pixel,
  input  wire                   cfg_we,
  input  wire                   cfg_index,
  input  wire gbf_pkg::cfg_t    cfg_wdata
);
  import gbf_pkg::*;

  localparam int SAT_W    = (MAX_COLUMNS < 8191) ? MAX_COLUMNS : 8191;
  localparam int IDX_W    = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int E_W      = 2 * CFG_W;
  localparam int D_W      = CFG_W;
  localparam int PROD_W   = WEIGHT_W + 1 + PIX_W;
  localparam int NUM_W    = PROD_W + 2;
  localparam int DEN_W    = WEIGHT_W + 2;
  localparam int REM_W    = DEN_W + 1;
  localparam int N_W      = NUM_W + 1;
  localparam int DIV_BITS = 2;
  localparam int DSTG     = PIX_W / DIV_BITS;

  typedef logic [WEIGHT_W-1:0] rom_t [WEIGHT_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] w;
    logic [95:0] p;
    logic [63:0] t;
    w = 64'h1_0000_0000;
    for (int e = 0; e < WEIGHT_TABLE_DEPTH; e++) begin
      if (e > 0) begin
        p = 96'(w) * 96'(DECAY_Q32) + 96'h8000_0000;
        w = p[95:32];
      end
      t = w + 64'h8000;
      rom[e] = t[32:16];
    end
    return rom;
  endfunction

  localparam rom_t WROM = build_rom();

  // ---------------- configuration ----------------
  cfg_t width_r, height_r, weff_r;
  logic [D_W-1:0] ctr_r [3];
  cfg_t weff_nxt;
  logic [CFG_W+15:0] ctr_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(64);
      height_r <= CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    weff_nxt = (width_r > CFG_W'(SAT_W)) ? CFG_W'(SAT_W) : width_r;
    ctr_prod = {16'd0, weff_nxt} * {{CFG_W{1'b0}}, RECIP6};
  end

  // beam centers are registered from the width and follow it in the next cycle
  always_ff @(posedge clk) begin
    weff_r    <= weff_nxt;
    ctr_r[0]  <= D_W'(ctr_prod >> RECIP6_SH);
    ctr_r[1]  <= D_W'(3 * (ctr_prod >> RECIP6_SH));
    ctr_r[2]  <= D_W'(5 * (ctr_prod >> RECIP6_SH));
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign out_valid = out_valid_r;

  // ---------------- stage 1: input register ----------------
  coord_t col_s1_r, row_s1_r;
  pixel_t val_s1_r [3];

  // ---------------- stage 2: distances, last flag ----------------
  logic [D_W-1:0] d_s2_r [3];
  pixel_t val_s2_r [3];
  logic last_s2_r;

  // ---------------- stage 3: squares ----------------
  logic [E_W-1:0] sq_s3_r [3];
  pixel_t val_s3_r [3];
  logic last_s3_r;

  // ---------------- stage 4: table index ----------------
  logic [IDX_W-1:0] idx_s4_r [3];
  logic ok_s4_r [3];
  pixel_t val_s4_r [3];
  logic last_s4_r;

  // ---------------- stage 5: weight rom ----------------
  weight_t w_s5_r [3];
  pixel_t val_s5_r [3];
  logic last_s5_r;

  // ---------------- stage 6: products ----------------
  logic signed [PROD_W-1:0] prod_s6_r [3];
  logic [DEN_W-1:0] den_s6_r;
  logic last_s6_r;

  // ---------------- stage 7: sums ----------------
  logic signed [NUM_W-1:0] num_s7_r;
  logic [DEN_W-1:0] den_s7_r;
  logic last_s7_r;

  logic [D_W-1:0]  col_ext;
  logic [E_W-1:0]  dmin;
  logic [E_W-1:0]  e_diff [3];
  logic [NUM_W-1:0] mag;
  logic [N_W-1:0]  n_div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_comb begin
    col_ext = {1'b0, col_s1_r};
    dmin = sq_s3_r[0];
    if (sq_s3_r[1] < dmin) dmin = sq_s3_r[1];
    if (sq_s3_r[2] < dmin) dmin = sq_s3_r[2];
    for (int b = 0; b < 3; b++) e_diff[b] = sq_s3_r[b] - dmin;
    mag   = num_s7_r[NUM_W-1] ? NUM_W'(-num_s7_r) : NUM_W'(num_s7_r);
    n_div = {mag, 1'b0} + N_W'(den_s7_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_s1_r    <= in_column_index;
      row_s1_r    <= in_row_index;
      val_s1_r[0] <= in_left_value;
      val_s1_r[1] <= in_center_value;
      val_s1_r[2] <= in_right_value;

      last_s2_r <= (weff_r != '0) && (height_r != '0)
                && (col_ext + CFG_W'(1) == weff_r)
                && ({1'b0, row_s1_r} + CFG_W'(1) == height_r);
      last_s3_r <= last_s2_r;
      last_s4_r <= last_s3_r;
      last_s5_r <= last_s4_r;
      last_s6_r <= last_s5_r;
      last_s7_r <= last_s6_r;

      for (int b = 0; b < 3; b++) begin
        d_s2_r[b]   <= (col_ext >= ctr_r[b]) ? col_ext - ctr_r[b] : ctr_r[b] - col_ext;
        val_s2_r[b] <= val_s1_r[b];
        sq_s3_r[b]  <= d_s2_r[b] * d_s2_r[b];
        val_s3_r[b] <= val_s2_r[b];
        ok_s4_r[b]  <= e_diff[b] < E_W'(WEIGHT_TABLE_DEPTH);
        idx_s4_r[b] <= e_diff[b][IDX_W-1:0];
        val_s4_r[b] <= val_s3_r[b];
        // one rom copy per beam
        w_s5_r[b]   <= ok_s4_r[b] ? WROM[idx_s4_r[b]] : '0;
        val_s5_r[b] <= val_s4_r[b];
        prod_s6_r[b] <= $signed({1'b0, w_s5_r[b]}) * val_s5_r[b];
      end
      den_s6_r <= DEN_W'(w_s5_r[0]) + DEN_W'(w_s5_r[1]) + DEN_W'(w_s5_r[2]);
      num_s7_r <= NUM_W'(prod_s6_r[0]) + NUM_W'(prod_s6_r[1]) + NUM_W'(prod_s6_r[2]);
      den_s7_r <= den_s6_r;
    end
  end

  // ---------------- divider: q = (2|num| + den) / (2 den) ----------------
  logic [REM_W-1:0] rem_r [DSTG+1];
  logic [PIX_W-1:0] nlo_r [DSTG+1];
  logic [PIX_W-1:0] quo_r [DSTG+1];
  logic [REM_W-1:0] dv_r  [DSTG+1];
  logic             neg_r [DSTG+1];
  logic             lst_r [DSTG+1];
  logic             vd_r  [DSTG+1];
  logic [REM_W-1:0] rem_nxt [DSTG];
  logic [PIX_W-1:0] nlo_nxt [DSTG];
  logic [PIX_W-1:0] quo_nxt [DSTG];

  // quotient fits 32 bits, so the top part of the dividend is below the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(n_div >> PIX_W);
      nlo_r[0] <= n_div[PIX_W-1:0];
      quo_r[0] <= '0;
      dv_r[0]  <= {den_s7_r, 1'b0};
      neg_r[0] <= num_s7_r[NUM_W-1];
      lst_r[0] <= last_s7_r;
    end
  end

  for (genvar k = 0; k < DSTG; k++) begin : g_div
    always_comb begin : step
      logic [REM_W-1:0] rem;
      logic [PIX_W-1:0] nlo;
      logic [PIX_W-1:0] quo;
      rem = rem_r[k];
      nlo = nlo_r[k];
      quo = quo_r[k];
      for (int j = 0; j < DIV_BITS; j++) begin
        rem = {rem[REM_W-2:0], nlo[PIX_W-1]};
        nlo = {nlo[PIX_W-2:0], 1'b0};
        if (rem >= dv_r[k]) begin
          rem = rem - dv_r[k];
          quo = {quo[PIX_W-2:0], 1'b1};
        end else begin
          quo = {quo[PIX_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      nlo_nxt[k] = nlo;
      quo_nxt[k] = quo;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (en) begin
        vd_r[k+1] <= vd_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt[k];
        nlo_r[k+1] <= nlo_nxt[k];
        quo_r[k+1] <= quo_nxt[k];
        dv_r[k+1]  <= dv_r[k];
        neg_r[k+1] <= neg_r[k];
        lst_r[k+1] <= lst_r[k];
      end
    end
  end

  // ---------------- output register ----------------
  pixel_t fused_r;
  logic   last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[DSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fused_r <= neg_r[DSTG] ? -$signed(quo_r[DSTG]) : $signed(quo_r[DSTG]);
      last_r  <= lst_r[DSTG];
    end
  end

  assign out_fused_value = fused_r;
  assign out_last_pixel  = last_r;

endmodule

`default_nettype wire

>>> hdl/gbf_checker.sv
// gbf_checker: port-level assertions for gaussian_beam_fusion
// no package dependency; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module gbf_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_fused_value,
  input wire        out_last_pixel
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fused_value)
                              && $stable(out_last_pixel))
    else $error("pending result changed");

  // empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a blocked output freezes the pipeline, so no transaction may enter
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

endmodule

bind gaussian_beam_fusion gbf_checker u_gbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_fused_value (out_fused_value),
  .out_last_pixel  (out_last_pixel)
);

`default_nettype wire

>>> tb/sv/gaussian_beam_fusion_checker.sv
// gaussian_beam_fusion_checker: watches the pixel and fused-value channels,
// predicts each fused pixel and compares; depends on gbf_pkg
`timescale 1ns / 1ps

module gaussian_beam_fusion_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire gbf_pkg::coord_t in_column_index,
  input  wire gbf_pkg::coord_t in_row_index,
  input  wire gbf_pkg::pixel_t in_left_value,
  input  wire gbf_pkg::pixel_t in_center_value,
  input  wire gbf_pkg::pixel_t in_right_value,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wire gbf_pkg::pixel_t out_fused_value,
  input  wire                  out_last_pixel,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire gbf_pkg::cfg_t   cfg_wdata,
  output int                   fail_count,
  output int                   pending_count
);
  import gbf_pkg::*;

  localparam int MAX_COLUMNS = 4096;
  localparam int TABLE_DEPTH = 4096;

  typedef struct packed {
    pixel_t fused;
    logic   last;
  } fused_pixel_t;

  logic [16:0]  weight_table [TABLE_DEPTH];
  cfg_t         width_reg, height_reg;
  fused_pixel_t fused_queue[$];

  assign pending_count = fused_queue.size();

  initial begin
    logic [63:0] w;
    w = 64'h1_0000_0000;
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      if (e > 0) w = (w * 64'(DECAY_Q32) + 64'h8000_0000) >> 32;
      weight_table[e] = 17'((w + 64'h8000) >> 16);
    end
    fail_count = 0;
  end

  function automatic longint beam_weight(longint e);
    if (e >= TABLE_DEPTH) return 0;
    return longint'(weight_table[e]);
  endfunction

  function automatic fused_pixel_t fuse_pixel(coord_t col, coord_t row, pixel_t vl,
                                              pixel_t vc, pixel_t vr);
    longint w, h, lc, cc, rc, dl, dc, dr, dmin, wl, wc, wr, num, den, mag, q;
    fused_pixel_t r;
    w = width_reg;
    h = height_reg;
    if (w > MAX_COLUMNS) w = MAX_COLUMNS;
    lc = w / 6;
    cc = 3 * lc;
    rc = 5 * lc;
    dl = (col - lc) * (col - lc);
    dc = (col - cc) * (col - cc);
    dr = (col - rc) * (col - rc);
    dmin = dl;
    if (dc < dmin) dmin = dc;
    if (dr < dmin) dmin = dr;
    wl = beam_weight(dl - dmin);
    wc = beam_weight(dc - dmin);
    wr = beam_weight(dr - dmin);
    num = wl * longint'(vl) + wc * longint'(vc) + wr * longint'(vr);
    den = wl + wc + wr;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    r.fused = pixel_t'(q);
    r.last = (w != 0 && h != 0 && col + 1 == w && row + 1 == h);
    return r;
  endfunction

  always @(posedge clk) begin
    fused_pixel_t exp_px;
    if (!rst_n) begin
      width_reg  <= 13'd64;
      height_reg <= 13'd64;
    end else begin
      if (in_valid && in_ready)
        fused_queue.push_back(fuse_pixel(in_column_index, in_row_index,
                                         in_left_value, in_center_value, in_right_value));
      if (out_valid && out_ready) begin
        if (fused_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transaction: fused %0d last %0b",
                     out_fused_value, out_last_pixel);
        end else begin
          exp_px = fused_queue.pop_front();
          if (exp_px.fused !== out_fused_value || exp_px.last !== out_last_pixel) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected fused %0d last %0b, got fused %0d last %0b",
                       exp_px.fused, exp_px.last, out_fused_value, out_last_pixel);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg <= cfg_wdata;
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg <= cfg_wdata;
      end
    end
  end
endmodule

>>> tb/sv/tb_gaussian_beam_fusion.sv
// tb_gaussian_beam_fusion: drives pixels and register writes into the fusion
// block and gives the verdict; depends on gbf_pkg and the checker module
`timescale 1ns / 1ps

module tb_gaussian_beam_fusion;
  import gbf_pkg::*;

  localparam int LATENCY = 25;
  localparam int STALL_LIMIT = 2000;

  logic   clk = 0, rst_n = 0;
  logic   in_valid = 0, out_ready = 0;
  coord_t in_column_index = '0, in_row_index = '0;
  pixel_t in_left_value = '0, in_center_value = '0, in_right_value = '0;
  logic   cfg_we = 0, cfg_index = REG_IMAGE_WIDTH;
  cfg_t   cfg_wdata = '0;
  logic   in_ready, out_valid, out_last_pixel;
  pixel_t out_fused_value;
  int     fail_count, pending_count, idle_cycles;
  logic   stim_done = 0;
  cfg_t   cur_width = 13'd64, cur_height = 13'd64;

  always #5 clk = ~clk;

  gaussian_beam_fusion dut (.*);
  gaussian_beam_fusion_checker checker_i (.*);

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side backpressure, with calm stretches
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  task automatic write_reg(logic idx, cfg_t val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_IMAGE_WIDTH) cur_width = val;
    else cur_height = val;
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic send_pixel(coord_t col, coord_t row, pixel_t l, pixel_t c, pixel_t r,
                            int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_column_index <= col;
    in_row_index <= row;
    in_left_value <= l;
    in_center_value <= c;
    in_right_value <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return pixel_t'($urandom_range(0, 200000)) - 100000;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  initial begin
    cfg_t widths[6] = '{13'd64, 13'd1, 13'd5, 13'd4096, 13'd8191, 13'd300};
    cfg_t heights[6] = '{13'd64, 13'd0, 13'd4096, 13'd8191, 13'd1, 13'd17};
    coord_t col;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, beam centers, last pixel, clipped weights
    send_pixel(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_pixel(4095, 4095, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    send_pixel(63, 63, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0);
    send_pixel(10, 5, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1);
    send_pixel(20, 5, 32'sh8000_0000, 32'sh7fff_ffff, -3, 0);
    send_pixel(31, 5, -1, 1, -1, 2);
    send_pixel(50, 5, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_pixel(4000, 0, 5, -7, 11, 0);
    send_pixel(12'hfff, 12'hfff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 0);
    // hold off until the pipeline is empty
    in_valid <= 0;
    drain_pipeline();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_IMAGE_WIDTH, widths[ph]);
      write_reg(REG_IMAGE_HEIGHT, heights[ph]);
      send_pixel(12'(widths[ph] - 1), 12'(heights[ph] - 1), -2, 3, 7, 0);
      for (int i = 0; i < 72; i++) begin
        if ($urandom_range(0, 1)) col = coord_t'($urandom_range(0, 4095));
        else if (cur_width > 1) col = coord_t'($urandom_range(0, cur_width - 1));
        else col = 0;
        send_pixel(col,
                   ($urandom_range(0, 3) == 0) ? coord_t'(cur_height - 1)
                                               : coord_t'($urandom),
                   rand_pixel(), rand_pixel(), rand_pixel(),
                   ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
      end
      in_valid <= 0;
      drain_pipeline();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> gaussian_beam_fusion.f
hdl/gbf_pkg.sv
hdl/gaussian_beam_fusion.sv
hdl/gbf_checker.sv
tb/sv/gaussian_beam_fusion_checker.sv
tb/sv/tb_gaussian_beam_fusion.sv
